[rtl/core/fpd_pkg.sv]
// Shared types and constants for the flight phase detector.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package fpd_pkg;

  localparam int ALT_W  = 24;  // altitude, filtered altitude and climb
  localparam int TIME_W = 32;  // millisecond timestamp
  localparam int ARM_W  = 23;  // arm altitude register
  localparam int CFG_W  = 32;  // widest configuration register
  localparam int IDX_W  = 2;   // configuration index
  localparam int PH_W   = 3;   // flight phase code

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ARM_LEVEL     = 2'd0;
  localparam logic [IDX_W-1:0] CFG_APEX_CLIMB    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_APOGEE_HOLD_MS = 2'd2;

  // configuration reset values
  localparam logic [ARM_W-1:0]  ARM_LEVEL_RST      = 23'd3000;
  localparam logic [ALT_W-1:0]  APEX_CLIMB_RST     = 24'd50;
  localparam logic [TIME_W-1:0] APOGEE_HOLD_MS_RST = 32'd4000;

  typedef struct packed {
    logic [ARM_W-1:0]         arm_level;
    logic signed [ALT_W-1:0]  apex_climb;
    logic [TIME_W-1:0]        apogee_hold_ms;
  } cfg_t;

  // window mean on its way to the phase stage
  typedef struct packed {
    logic                     valid;
    logic signed [ALT_W-1:0]  filtered;
    logic [TIME_W-1:0]        time_ms;
  } mean_t;

endpackage

`default_nettype wire

[rtl/core/flight_phase_detector_unit.sv]
// Top level of the flight phase detector: sample window, running sum,
// config registers. Uses fpd_pkg, fpd_cell, fpd_mean, fpd_phase.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_stall, altitude_cm, time_ms     | in / stall out
//  output  | out_valid, out_stall, filtered_altitude,     | out / stall in
//          | climb, flight_phase                          |
//  config  | cfg_write, cfg_index, cfg_data               | in, write only
//
// One transaction per clock sustained unless the output stalls; each result
// passes the window sum, the fpd_mean stages and the phase output register.
// Throughput is set by the window-sum accumulator and the phase register,
// each updated once per transaction.
// Synchronous reset clears the window cells, sum, phase and climb history and
// loads the config reset values; no clearing pass is needed.
// A stalled output only blocks the input once every pipeline stage is full.
`default_nettype none

module flight_phase_detector_unit #(
  parameter int WINDOW_SIZE = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fpd_pkg::ALT_W-1:0]   altitude_cm,
  input  logic [fpd_pkg::TIME_W-1:0]         time_ms,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fpd_pkg::ALT_W-1:0]   filtered_altitude,
  output logic signed [fpd_pkg::ALT_W-1:0]   climb,
  output logic [fpd_pkg::PH_W-1:0]           flight_phase,
  // configuration
  input  logic                               cfg_write,
  input  logic [fpd_pkg::IDX_W-1:0]          cfg_index,
  input  logic [fpd_pkg::CFG_W-1:0]          cfg_data
);

  localparam int ALT_W = fpd_pkg::ALT_W;
  localparam int SUM_W = ALT_W + $clog2(WINDOW_SIZE);

  fpd_pkg::cfg_t  cfg;
  fpd_pkg::mean_t mean;

  logic                    accept;
  logic                    v_a, ready_a, mean_ready, phase_ready;
  logic signed [SUM_W-1:0] window_sum;
  logic [fpd_pkg::TIME_W-1:0] time_a;
  logic signed [ALT_W-1:0] tap [WINDOW_SIZE];
  logic signed [ALT_W-1:0] oldest;

  assign ready_a  = !v_a || mean_ready;
  assign in_stall = !ready_a;
  assign accept   = in_valid && ready_a;

  // chain of cells: newest sample enters cell 0, oldest leaves the last cell
  for (genvar k = 0; k < WINDOW_SIZE; k++) begin : g_cell
    fpd_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .d     ((k == 0) ? altitude_cm : tap[(k == 0) ? 0 : k - 1]),
      .q     (tap[k])
    );
  end

  assign oldest = tap[WINDOW_SIZE-1];

  // running sum of the window, also the payload of the first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a        <= 1'b0;
      window_sum <= '0;
    end else begin
      if (ready_a) begin
        v_a <= in_valid;
      end
      if (accept) begin
        window_sum <= window_sum
                    - {{(SUM_W-ALT_W){oldest[ALT_W-1]}}, oldest}
                    + {{(SUM_W-ALT_W){altitude_cm[ALT_W-1]}}, altitude_cm};
        time_a     <= time_ms;
      end
    end
  end

  // config registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_level      <= fpd_pkg::ARM_LEVEL_RST;
      cfg.apex_climb     <= fpd_pkg::APEX_CLIMB_RST;
      cfg.apogee_hold_ms <= fpd_pkg::APOGEE_HOLD_MS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        fpd_pkg::CFG_ARM_LEVEL:
          cfg.arm_level <= cfg_data[fpd_pkg::ARM_W-1:0];
        fpd_pkg::CFG_APEX_CLIMB:
          cfg.apex_climb <= cfg_data[ALT_W-1:0];
        fpd_pkg::CFG_APOGEE_HOLD_MS:
          cfg.apogee_hold_ms <= cfg_data[fpd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  fpd_mean #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_mean (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_a),
    .in_ready  (mean_ready),
    .sum       (window_sum),
    .time_ms   (time_a),
    .res       (mean),
    .res_ready (phase_ready)
  );

  fpd_phase u_phase (
    .clk               (clk),
    .rst               (rst),
    .m                 (mean),
    .m_ready           (phase_ready),
    .cfg               (cfg),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .filtered_altitude (filtered_altitude),
    .climb             (climb),
    .flight_phase      (flight_phase)
  );

endmodule

`default_nettype wire

[rtl/core/fpd_cell.sv]
// One cell of the sample window: holds one altitude sample.
// Takes its neighbour's sample on every shift. Uses fpd_pkg.
`default_nettype none

module fpd_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              shift,
  input  logic signed [fpd_pkg::ALT_W-1:0]  d,
  output logic signed [fpd_pkg::ALT_W-1:0]  q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/fpd_mean.sv]
// Window sum to mean: sum / WINDOW_SIZE truncated toward zero.
// Four stages: magnitude, reciprocal multiply, correction, sign. Uses fpd_pkg.
`default_nettype none

module fpd_mean #(
  parameter int WINDOW_SIZE = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [fpd_pkg::ALT_W+$clog2(WINDOW_SIZE)-1:0] sum,
  input  logic [fpd_pkg::TIME_W-1:0]                 time_ms,
  output fpd_pkg::mean_t                             res,
  input  logic                                       res_ready
);

  localparam int SUM_W = fpd_pkg::ALT_W + $clog2(WINDOW_SIZE);
  localparam int ALT_W = fpd_pkg::ALT_W;
  localparam int TW    = fpd_pkg::TIME_W;
  localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW_SIZE);
  // floor(2^SUM_W / W): the estimate is short by at most one
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WINDOW_SIZE);

  // stage B: magnitude
  logic               v_b;
  logic [SUM_W-1:0]   abs_b;
  logic               neg_b;
  logic [TW-1:0]      time_b;
  // stage C: product
  logic               v_c;
  logic [2*SUM_W-1:0] prod_c;
  logic [SUM_W-1:0]   abs_c;
  logic               neg_c;
  logic [TW-1:0]      time_c;
  // stage D: corrected quotient
  logic               v_d;
  logic [ALT_W-1:0]   q_d;
  logic               neg_d;
  logic [TW-1:0]      time_d;

  logic ready_b, ready_c, ready_d, ready_e;

  logic [SUM_W-1:0] q_est, q_w, rem, q_fix;

  assign ready_e  = !res.valid || res_ready;
  assign ready_d  = !v_d || ready_e;
  assign ready_c  = !v_c || ready_d;
  assign ready_b  = !v_b || ready_c;
  assign in_ready = ready_b;

  assign q_est = prod_c[2*SUM_W-1 -: SUM_W];
  assign q_w   = SUM_W'(q_est * WIN_C);
  assign rem   = abs_c - q_w;
  assign q_fix = q_est + SUM_W'(rem >= WIN_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (ready_b) begin
        v_b    <= in_valid;
        neg_b  <= sum[SUM_W-1];
        abs_b  <= sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
        time_b <= time_ms;
      end
      if (ready_c) begin
        v_c    <= v_b;
        prod_c <= {{SUM_W{1'b0}}, abs_b} * {{SUM_W{1'b0}}, RECIP};
        abs_c  <= abs_b;
        neg_c  <= neg_b;
        time_c <= time_b;
      end
      if (ready_d) begin
        v_d    <= v_c;
        q_d    <= q_fix[ALT_W-1:0];
        neg_d  <= neg_c;
        time_d <= time_c;
      end
      if (ready_e) begin
        res.valid    <= v_d;
        res.filtered <= neg_d ? -$signed(q_d) : $signed(q_d);
        res.time_ms  <= time_d;
      end
    end
  end

  // reciprocal estimate is never more than one short
  a_est_close: assert property (@(posedge clk) disable iff (rst)
    v_c |-> (rem < (WIN_C << 1)))
    else $error("mean estimate off by more than one");

endmodule

`default_nettype wire

[rtl/core/fpd_phase.sv]
// Climb and five-phase flight state machine; holds the output register.
// Uses fpd_pkg (mean_t, cfg_t).
`default_nettype none

module fpd_phase (
  input  logic                               clk,
  input  logic                               rst,
  input  fpd_pkg::mean_t                     m,
  output logic                               m_ready,
  input  fpd_pkg::cfg_t                      cfg,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fpd_pkg::ALT_W-1:0]   filtered_altitude,
  output logic signed [fpd_pkg::ALT_W-1:0]   climb,
  output logic [fpd_pkg::PH_W-1:0]           flight_phase
);

  localparam int ALT_W = fpd_pkg::ALT_W;
  localparam int TW    = fpd_pkg::TIME_W;
  localparam logic signed [ALT_W-1:0] S24_MAX = {1'b0, {(ALT_W-1){1'b1}}};
  localparam logic signed [ALT_W-1:0] S24_MIN = {1'b1, {(ALT_W-1){1'b0}}};

  typedef enum logic [fpd_pkg::PH_W-1:0] {
    PH_IDLE       = 3'd0,
    PH_ASCENDING  = 3'd1,
    PH_APOGEE     = 3'd2,
    PH_DESCENDING = 3'd3,
    PH_LANDED     = 3'd4
  } phase_t;

  phase_t              phase, phase_next;
  logic [TW-1:0]       apogee_start, start_next;
  logic signed [ALT_W:0]   diff;
  logic signed [ALT_W-1:0] climb_next;
  logic [TW-1:0]       elapsed;
  logic                load, above_arm, below_arm, slow, hold_done;

  assign m_ready      = !out_valid || !out_stall;
  assign load         = m.valid && m_ready;
  assign flight_phase = phase;

  assign diff = {m.filtered[ALT_W-1], m.filtered}
              - {filtered_altitude[ALT_W-1], filtered_altitude};

  always_comb begin
    if (diff[ALT_W] != diff[ALT_W-1]) begin
      climb_next = diff[ALT_W] ? S24_MIN : S24_MAX;
    end else begin
      climb_next = diff[ALT_W-1:0];
    end
  end

  assign above_arm = $signed(m.filtered) > $signed({1'b0, cfg.arm_level});
  assign below_arm = $signed(m.filtered) < $signed({1'b0, cfg.arm_level});
  assign slow      = climb_next < cfg.apex_climb;
  assign elapsed   = m.time_ms - apogee_start;   // wraps safely mod 2^32
  assign hold_done = elapsed > cfg.apogee_hold_ms;

  // transitions may cascade; new apogee cannot end now (checks old phase)
  always_comb begin
    phase_next = phase;
    start_next = apogee_start;
    if (phase_next == PH_IDLE && above_arm) begin
      phase_next = PH_ASCENDING;
    end
    if (phase_next == PH_ASCENDING && slow) begin
      phase_next = PH_APOGEE;
      start_next = m.time_ms;
    end
    if (phase == PH_APOGEE && hold_done) begin
      phase_next = PH_DESCENDING;
    end
    if (phase_next == PH_DESCENDING && below_arm) begin
      phase_next = PH_LANDED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      phase             <= PH_IDLE;
      filtered_altitude <= '0;
      apogee_start      <= '0;
    end else begin
      if (m_ready) begin
        out_valid <= m.valid;
      end
      if (load) begin
        filtered_altitude <= m.filtered;
        climb             <= climb_next;
        phase             <= phase_next;
        apogee_start      <= start_next;
      end
    end
  end

  a_landed_final: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LANDED) |=> (phase == PH_LANDED))
    else $error("left landed phase");

  a_idle_reach: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |=> (phase != PH_DESCENDING && phase != PH_LANDED))
    else $error("idle skipped the apogee hold");

  a_phase_held: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(phase) && $stable(apogee_start))
    else $error("phase state moved without a transaction");

endmodule

`default_nettype wire
